### rtl/core/olist_pkg.sv
package olist_pkg;

    localparam int CAPACITY = 16;

    // pointer into the entry store, and a count that can hold CAPACITY itself
    localparam int PTR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int COUNT_W = 5;
    localparam int VALUE_W = 32;

    // operation codes
    localparam logic [1:0] KIND_FRONT  = 2'd0;
    localparam logic [1:0] KIND_BACK   = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;
    localparam logic [1:0] KIND_SEARCH = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [VALUE_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
    } t_out_beat;

    typedef struct packed {
        logic       valid;
        t_out_beat  beat;
    } t_seq_result;

    typedef struct packed {
        logic               en;
        logic [PTR_W-1:0]   addr;
        logic [VALUE_W-1:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
    } t_ram_rd;

    // circular add of a logical offset to a physical slot
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(a) + (CNT_W+1)'(b);
        if (sum >= (CNT_W+1)'(CAPACITY)) begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return PTR_W'(sum);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] a);
        logic [PTR_W-1:0] r;
        if (a == PTR_W'(CAPACITY - 1)) begin
            r = '0;
        end else begin
            r = a + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] a);
        logic [PTR_W-1:0] r;
        if (a == '0) begin
            r = PTR_W'(CAPACITY - 1);
        end else begin
            r = a - 1'b1;
        end
        return r;
    endfunction

endpackage

### rtl/core/olist_ram.sv
module olist_ram
    import olist_pkg::*;
(
    input  logic               i_clk,
    input  t_ram_wr            i_wr,
    input  t_ram_rd            i_rd,
    output logic [VALUE_W-1:0] o_rd_data
);

    logic [VALUE_W-1:0] r_mem [CAPACITY];
    logic [VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/olist_seq.sv
module olist_seq
    import olist_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  t_in_beat           i_req,
    output logic               o_req_ready,
    output t_seq_result        o_result,
    input  logic               i_take,
    output t_ram_wr            o_wr,
    output t_ram_rd            o_rd,
    input  logic [VALUE_W-1:0] i_rd_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [PTR_W-1:0]   r_addr, n_addr;
    logic [PTR_W-1:0]   r_prev, n_prev;
    logic [1:0]         r_kind, n_kind;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [1:0]         r_status, n_status;

    logic hit;
    logic last;
    logic full;

    assign hit  = (i_rd_data == r_value);
    assign last = (r_idx == CNT_W'(r_count - 1'b1));
    assign full = (r_count == CNT_W'(CAPACITY));

    assign o_req_ready          = (r_state == S_IDLE);
    assign o_result.valid       = (r_state == S_DONE);
    assign o_result.beat.status = r_status;
    assign o_result.beat.entry_count = COUNT_W'(r_count);

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_idx    = r_idx;
        n_addr   = r_addr;
        n_prev   = r_prev;
        n_kind   = r_kind;
        n_value  = r_value;
        n_status = r_status;
        o_wr     = '0;
        o_rd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_kind  = i_req.kind;
                    n_value = $unsigned(i_req.value);
                    case (i_req.kind)
                        KIND_FRONT, KIND_BACK: begin
                            n_state = S_DONE;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status  = ST_OK;
                                n_count   = r_count + 1'b1;
                                o_wr.en   = 1'b1;
                                o_wr.data = $unsigned(i_req.value);
                                if (i_req.kind == KIND_FRONT) begin
                                    n_head    = ptr_dec(r_head);
                                    o_wr.addr = ptr_dec(r_head);
                                end else begin
                                    o_wr.addr = wrap_add(r_head, r_count);
                                end
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_status = ST_NOTFOUND;
                                n_state  = S_DONE;
                            end else begin
                                o_rd.en   = 1'b1;
                                o_rd.addr = r_head;
                                n_addr    = r_head;
                                n_idx     = '0;
                                n_state   = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit && (r_kind == KIND_SEARCH)) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else if (hit && last) begin
                    n_status = ST_OK;
                    n_count  = r_count - 1'b1;
                    n_state  = S_DONE;
                end else if (!hit && last) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_DONE;
                end else begin
                    // fetch the next entry; a delete hit moves on to closing up
                    o_rd.en   = 1'b1;
                    o_rd.addr = ptr_inc(r_addr);
                    n_prev    = r_addr;
                    n_addr    = ptr_inc(r_addr);
                    n_idx     = r_idx + 1'b1;
                    if (hit) begin
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                o_wr.en   = 1'b1;
                o_wr.addr = r_prev;
                o_wr.data = i_rd_data;
                if (last) begin
                    n_status = ST_OK;
                    n_count  = r_count - 1'b1;
                    n_state  = S_DONE;
                end else begin
                    o_rd.en   = 1'b1;
                    o_rd.addr = ptr_inc(r_addr);
                    n_prev    = r_addr;
                    n_addr    = ptr_inc(r_addr);
                    n_idx     = r_idx + 1'b1;
                end
            end
            default: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_addr   <= n_addr;
        r_prev   <= n_prev;
        r_kind   <= n_kind;
        r_value  <= n_value;
        r_status <= n_status;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_shift_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_idx != '0) && (r_kind == KIND_DELETE))
        else $error("close-up pass without a deleted slot");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready && !full &&
         (i_req.kind == KIND_FRONT || i_req.kind == KIND_BACK))
        |=> (r_count == $past(r_count) + 1'b1) && (r_status == ST_OK))
        else $error("insert did not add an entry");

    a_search_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && (r_kind == KIND_SEARCH)) |=> $stable(r_count))
        else $error("search changed the entry count");
`endif

endmodule

### rtl/core/ordered_list_engine.sv
// channel  direction  beat        handshake
// in       input      t_in_beat   i_in_valid / o_in_ready
// out      output     t_out_beat  o_out_valid / i_out_ready
//
// one item at a time; o_in_ready is high only while the sequencer is idle
// inserts finish without a walk; delete and search walk the entry store
//   through its single registered read port
// delete closes up the list in the same walk, one entry moved per cycle
// reset (synchronous, active low) empties the list; the store itself is not cleared
// an output register holds a finished result, so a stalled consumer does not
//   block the next accepted item until the following result is ready
module ordered_list_engine
    import olist_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    t_seq_result        seq_result;
    t_ram_wr            ram_wr;
    t_ram_rd            ram_rd;
    logic [VALUE_W-1:0] ram_rd_data;
    logic               take;

    logic      r_out_valid;
    t_out_beat r_out_data;

    // entry store, kept as a circular buffer: head pointer plus count
    olist_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd      (ram_rd),
        .o_rd_data (ram_rd_data)
    );

    // sequencer with the shared compare unit that walks the list
    olist_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .i_req       (i_in_data),
        .o_req_ready (o_in_ready),
        .o_result    (seq_result),
        .i_take      (take),
        .o_wr        (ram_wr),
        .o_rd        (ram_rd),
        .i_rd_data   (ram_rd_data)
    );

    // result moves into the output register when it is empty or being drained
    assign take = seq_result.valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= seq_result.beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
